// ----- hdl/prt_pkg.sv -----
// ---------------------------------------------------------------------------
// prt_pkg: shared types for the prescaled reload timer
// Request kinds, register numbers, bit positions and the beat and status
// structures that pass between the timer's register core and its top level.
// ---------------------------------------------------------------------------
package prt_pkg;

   localparam int unsigned DATA_WIDTH = 16;
   localparam int unsigned SEL_WIDTH  = 3;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_IDLE  = 2'd3
   } req_kind_type;

   typedef enum logic [SEL_WIDTH-1:0] {
      REG_CONTROL  = 3'd0,
      REG_IRQ_EN   = 3'd1,
      REG_STATUS   = 3'd2,
      REG_EVENT    = 3'd3,
      REG_COUNTER  = 3'd4,
      REG_PRESCALE = 3'd5,
      REG_RELOAD   = 3'd6
   } reg_sel_type;

   // Bit positions inside register words.
   localparam int unsigned CTRL_ENABLE_BIT = 0;
   localparam int unsigned CTRL_OPM_BIT    = 1;
   localparam int unsigned FLAG_BIT        = 0;

   typedef struct packed {
      req_kind_type          kind;
      logic [SEL_WIDTH-1:0]  sel;
      logic [DATA_WIDTH-1:0] data;
   } req_beat_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic                  update_pulse;
      logic                  irq_pending;
      logic                  running;
   } rsp_beat_type;

   typedef struct packed {
      logic count_enable;
      logic one_pulse_mode;
      logic update_irq_enable;
      logic update_flag;
   } timer_status_type;

endpackage

// ----- hdl/prt_regs.sv -----
// ---------------------------------------------------------------------------
// prt_regs: timer register file and counting core
// Holds the control bits, the counter, the prescaler with its shadow and the
// reload value. Computes the next state and the response beat of one request.
// ---------------------------------------------------------------------------
module prt_regs #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_go,
   input  prt_pkg::req_beat_type     req_beat,
   output prt_pkg::rsp_beat_type     rsp_beat,
   output prt_pkg::timer_status_type status
);
   import prt_pkg::*;

   logic                   count_enable_ff,      count_enable_in;
   logic                   one_pulse_mode_ff,    one_pulse_mode_in;
   logic                   update_irq_enable_ff, update_irq_enable_in;
   logic                   update_flag_ff,       update_flag_in;
   logic [COUNT_WIDTH-1:0] main_count_ff,        main_count_in;
   logic [DATA_WIDTH-1:0]  prescale_count_ff,    prescale_count_in;
   logic [DATA_WIDTH-1:0]  prescale_preload_ff,  prescale_preload_in;
   logic [DATA_WIDTH-1:0]  prescale_active_ff,   prescale_active_in;
   logic [COUNT_WIDTH-1:0] reload_value_ff,      reload_value_in;

   logic [COUNT_WIDTH-1:0] write_count;
   logic [DATA_WIDTH-1:0]  read_word;
   logic                   pulse;

   // Write data resized to the counter width (zero fill or truncation).
   assign write_count = COUNT_WIDTH'(req_beat.data);

   always_comb begin
      count_enable_in      = count_enable_ff;
      one_pulse_mode_in    = one_pulse_mode_ff;
      update_irq_enable_in = update_irq_enable_ff;
      update_flag_in       = update_flag_ff;
      main_count_in        = main_count_ff;
      prescale_count_in    = prescale_count_ff;
      prescale_preload_in  = prescale_preload_ff;
      prescale_active_in   = prescale_active_ff;
      reload_value_in      = reload_value_ff;
      read_word            = '0;
      pulse                = 1'b0;

      unique case (req_beat.kind)
         REQ_TICK: begin
            if (count_enable_ff) begin
               if (prescale_count_ff >= prescale_active_ff) begin
                  prescale_count_in = '0;
                  // A zero reload value blocks the counter.
                  if (reload_value_ff != '0) begin
                     if (main_count_ff == reload_value_ff) begin
                        main_count_in      = '0;
                        update_flag_in     = 1'b1;
                        prescale_active_in = prescale_preload_ff;
                        pulse              = 1'b1;
                        if (one_pulse_mode_ff) begin
                           count_enable_in = 1'b0;
                        end
                     end else begin
                        main_count_in = main_count_ff + 1'b1;
                     end
                  end
               end else begin
                  prescale_count_in = prescale_count_ff + 1'b1;
               end
            end
         end
         REQ_WRITE: begin
            unique case (req_beat.sel)
               REG_CONTROL: begin
                  count_enable_in   = req_beat.data[CTRL_ENABLE_BIT];
                  one_pulse_mode_in = req_beat.data[CTRL_OPM_BIT];
               end
               REG_IRQ_EN: begin
                  update_irq_enable_in = req_beat.data[FLAG_BIT];
               end
               REG_STATUS: begin
                  if (!req_beat.data[FLAG_BIT]) begin
                     update_flag_in = 1'b0;
                  end
               end
               REG_EVENT: begin
                  // Software update: both counters restart, the enable stays.
                  if (req_beat.data[FLAG_BIT]) begin
                     main_count_in      = '0;
                     prescale_count_in  = '0;
                     update_flag_in     = 1'b1;
                     prescale_active_in = prescale_preload_ff;
                     pulse              = 1'b1;
                  end
               end
               REG_COUNTER:  main_count_in       = write_count;
               REG_PRESCALE: prescale_preload_in = req_beat.data;
               REG_RELOAD:   reload_value_in     = write_count;
               default: ;
            endcase
         end
         REQ_READ: begin
            unique case (req_beat.sel)
               REG_CONTROL: begin
                  read_word[CTRL_ENABLE_BIT] = count_enable_ff;
                  read_word[CTRL_OPM_BIT]    = one_pulse_mode_ff;
               end
               REG_IRQ_EN:   read_word[FLAG_BIT] = update_irq_enable_ff;
               REG_STATUS:   read_word[FLAG_BIT] = update_flag_ff;
               REG_COUNTER:  read_word = DATA_WIDTH'(main_count_ff);
               REG_PRESCALE: read_word = prescale_preload_ff;
               REG_RELOAD:   read_word = DATA_WIDTH'(reload_value_ff);
               default:      read_word = '0;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_enable_ff      <= 1'b0;
         one_pulse_mode_ff    <= 1'b0;
         update_irq_enable_ff <= 1'b0;
         update_flag_ff       <= 1'b0;
         main_count_ff        <= '0;
         prescale_count_ff    <= '0;
         prescale_preload_ff  <= '0;
         prescale_active_ff   <= '0;
         reload_value_ff      <= '1;
      end else if (req_go) begin
         count_enable_ff      <= count_enable_in;
         one_pulse_mode_ff    <= one_pulse_mode_in;
         update_irq_enable_ff <= update_irq_enable_in;
         update_flag_ff       <= update_flag_in;
         main_count_ff        <= main_count_in;
         prescale_count_ff    <= prescale_count_in;
         prescale_preload_ff  <= prescale_preload_in;
         prescale_active_ff   <= prescale_active_in;
         reload_value_ff      <= reload_value_in;
      end
   end

   assign rsp_beat.read_data    = read_word;
   assign rsp_beat.update_pulse = pulse;
   assign rsp_beat.irq_pending  = update_flag_in && update_irq_enable_in;
   assign rsp_beat.running      = count_enable_in;

   assign status.count_enable      = count_enable_ff;
   assign status.one_pulse_mode    = one_pulse_mode_ff;
   assign status.update_irq_enable = update_irq_enable_ff;
   assign status.update_flag       = update_flag_ff;

endmodule

// ----- hdl/prescaled_reload_timer.sv -----
// ---------------------------------------------------------------------------
// prescaled_reload_timer: up-counting timer with prescaler and auto-reload
// Each request beat is a clock tick, a register write or a register read;
// each one returns exactly one response beat.
// ---------------------------------------------------------------------------
// The timer takes one request beat per clock cycle and answers it with one
// response beat in the following cycle. All the work of a beat, the prescaler
// and counter step, the register write or the register read, is done by the
// register core in the cycle the beat is accepted, and the response lands in
// a single output register. While that register holds a beat that the
// consumer stalls, req_stall is raised and the timer's state is frozen; at all
// other times a new request is taken every cycle. A tick advances the
// prescaler only while the enable bit is set; when the prescaler has reached
// the active prescale value it wraps and the counter steps. A counter equal to
// the reload value returns to zero, raises the update flag, loads the
// prescaler shadow into the active value and, in one-pulse mode, clears the
// enable. A reload value of zero holds the counter still. Writing the
// update-generate bit forces an update without touching the enable. Writing
// zero to the status bit clears the flag, writing one leaves it alone.
// irq_pending is the update flag ANDed with the interrupt enable, and running
// is the enable bit, both as they stand after the beat.
// ---------------------------------------------------------------------------
module prescaled_reload_timer #(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [prt_pkg::SEL_WIDTH-1:0]       req_reg_select,
   input  logic [prt_pkg::DATA_WIDTH-1:0]      req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prt_pkg::DATA_WIDTH-1:0]      rsp_read_data,
   output logic                                rsp_update_pulse,
   output logic                                rsp_irq_pending,
   output logic                                rsp_running
);
   import prt_pkg::*;

   req_beat_type     req_beat;
   rsp_beat_type     core_rsp;
   timer_status_type status;
   logic             req_go;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_beat_ff;

   // The output register is free when empty or when its beat leaves now.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_go    = req_valid && !req_stall;

   assign req_beat.kind = req_kind_type'(req_type);
   assign req_beat.sel  = req_reg_select;
   assign req_beat.data = req_write_data;

   prt_regs #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_regs (
      .clock    (clock),
      .reset    (reset),
      .req_go   (req_go),
      .req_beat (req_beat),
      .rsp_beat (core_rsp),
      .status   (status)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset; it is qualified by rsp_valid.
   always_ff @(posedge clock) begin
      if (req_go) begin
         rsp_beat_ff <= core_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_beat_ff.read_data;
   assign rsp_update_pulse = rsp_beat_ff.update_pulse;
   assign rsp_irq_pending  = rsp_beat_ff.irq_pending;
   assign rsp_running      = rsp_beat_ff.running;

`ifndef NO_ASSERTIONS
   // Every accepted request produces a response beat in the next cycle.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response beat");

   // An update pulse comes from a tick or a write, never from a read.
   a_pulse_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_pulse |-> rsp_read_data == '0)
      else $error("update pulse reported with read data");

   // An update event leaves the flag set and irq_pending tracks the enable.
   a_pulse_sets_flag: assert property (@(posedge clock) disable iff (reset)
      req_go && core_rsp.update_pulse |=>
         status.update_flag && (rsp_irq_pending == status.update_irq_enable))
      else $error("update event did not set the update flag");

   // Timer state only moves when a request beat is accepted.
   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      !req_go |=> $stable(status))
      else $error("timer state changed without an accepted request");
`endif

endmodule
